// File: hdl/ord_pkg.sv
// Package for the overwriting ring deque: sizes, command codes, the result
// record and the pointer wrap helpers.
// Depends on nothing; every other file of the block imports it.
package ord_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CMD_W      = 3;
    localparam int IDX_W      = 4;
    localparam int RD_W       = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_READ       = 3'd4,
        CMD_CLEAR      = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [RD_W-1:0]  read_data;
        logic             index_error;
        logic [CNT_W-1:0] element_count;
        logic             is_empty;
        logic             is_full;
    } rsp_t;

    // Step forward by one slot, wrapping at the configured capacity.
    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p,
                                                   input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] sum;
        sum = {{(CNT_W-PTR_W){1'b0}}, p} + CNT_W'(1);
        return (sum >= cap) ? '0 : sum[PTR_W-1:0];
    endfunction

    // Step back by one slot, wrapping to the last slot of the configured capacity.
    function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] p,
                                                   input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] last;
        last = cap - CNT_W'(1);
        return (p == '0) ? last[PTR_W-1:0] : p - PTR_W'(1);
    endfunction

endpackage

// File: hdl/ord_channels.sv
// Valid/ready channel interfaces for the ring deque: command beats in and
// result beats out. Depends on ord_pkg for the field widths.
interface ord_cmd_if
    import ord_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [31:0]      element_value;
    logic [IDX_W-1:0] read_index;

    modport source (output valid, cmd, element_value, read_index, input ready);
    modport sink   (input valid, cmd, element_value, read_index, output ready);
endinterface

interface ord_rsp_if
    import ord_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RD_W-1:0]  read_data;
    logic             index_error;
    logic [CNT_W-1:0] element_count;
    logic             is_empty;
    logic             is_full;

    modport source (output valid, read_data, index_error, element_count, is_empty,
                    is_full, input ready);
    modport sink   (input valid, read_data, index_error, element_count, is_empty,
                    is_full, output ready);
endinterface

// File: hdl/ord_rsp_buf.sv
// Two-entry result buffer: an output register plus a skid register, so the
// input side sees a registered ready. Depends on ord_pkg and ord_channels.
module ord_rsp_buf
    import ord_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  rsp_t       push_data,
    ord_rsp_if.source  rsp
);

    logic main_valid_reg, main_valid_next;
    logic skid_valid_reg, skid_valid_next;
    rsp_t main_data_reg, main_data_next;
    rsp_t skid_data_reg, skid_data_next;
    logic take;
    logic drain;

    assign push_ready = !skid_valid_reg;
    assign take       = push_valid && push_ready;
    assign drain      = main_valid_reg && rsp.ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (drain || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = take;
                main_data_next  = push_data;
            end
        end
        else if (take)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign rsp.valid         = main_valid_reg;
    assign rsp.read_data     = main_data_reg.read_data;
    assign rsp.index_error   = main_data_reg.index_error;
    assign rsp.element_count = main_data_reg.element_count;
    assign rsp.is_empty      = main_data_reg.is_empty;
    assign rsp.is_full       = main_data_reg.is_full;

endmodule

// File: hdl/overwriting_ring_deque.sv
// Top level of the overwriting ring deque: slot storage, pointers, command
// decode and the capacity register. Depends on ord_pkg, ord_channels and
// ord_rsp_buf.
//
//   Channel   Dir   Handshake        Carries
//   cmd       in    valid/ready      cmd, element_value, read_index
//   rsp       out   valid/ready      read_data, index_error, element_count,
//                                    is_empty, is_full
//   cfg       in    cfg_we only      capacity (cfg_wdata)
//
// One command beat is taken per cycle while cmd.ready is high. The command
// is decoded and the slots, pointers and count are updated at the edge that
// accepts it (a beat taken while cfg_we is high is dropped); the result is
// registered at that same edge. Reset leaves capacity at DEPTH and the deque
// empty; slot contents are not reset. The result side has an output register
// and a skid register, so one stalled result does not stop intake; cmd.ready
// falls only when both hold results; rsp is driven from the output register.
module overwriting_ring_deque
    import ord_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    ord_cmd_if.sink          cmd,
    ord_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    logic [DATA_WIDTH-1:0] slots_reg [DEPTH];

    logic [CNT_W-1:0] cap_reg, cap_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             accept;
    logic             buf_ready;
    logic             full;
    logic             slot_we;
    logic [PTR_W-1:0] slot_waddr;
    logic [PTR_W-1:0] inc_head;
    logic [PTR_W-1:0] inc_tail;
    logic [PTR_W-1:0] dec_head;
    logic [PTR_W-1:0] dec_tail;
    logic [CNT_W-1:0] read_pos;
    logic [CNT_W-1:0] read_idx;
    logic [CNT_W-1:0] cap_clamp;
    logic [CNT_W-1:0] cap_last;
    rsp_t             result;

    assign cmd.ready = buf_ready;
    assign accept    = cmd.valid && buf_ready;
    assign full      = (count_reg == cap_reg);
    assign inc_head  = wrap_inc(head_reg, cap_reg);
    assign inc_tail  = wrap_inc(tail_reg, cap_reg);
    assign dec_head  = wrap_dec(head_reg, cap_reg);
    assign dec_tail  = wrap_dec(tail_reg, cap_reg);
    assign read_idx  = CNT_W'(cmd.read_index);
    assign cap_last  = (cfg_we ? cap_clamp : cap_reg) - CNT_W'(1);

    // A new capacity is clamped into 1..DEPTH.
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cap_clamp = CNT_W'(1);
        end
        else if (cfg_wdata > CNT_W'(DEPTH))
        begin
            cap_clamp = CNT_W'(DEPTH);
        end
        else
        begin
            cap_clamp = cfg_wdata;
        end
    end

    // The read position is head plus index; for an index below the count both are
    // below the capacity, so one conditional subtract wraps it.
    always_comb
    begin
        read_pos = {{(CNT_W-PTR_W){1'b0}}, head_reg} + read_idx;
        if (read_pos >= cap_reg)
        begin
            read_pos = read_pos - cap_reg;
        end
    end

    always_comb
    begin
        cap_next             = cap_reg;
        head_next            = head_reg;
        tail_next            = tail_reg;
        count_next           = count_reg;
        slot_we              = 1'b0;
        slot_waddr           = head_reg;
        result.read_data     = '0;
        result.index_error   = 1'b0;

        if (cfg_we)
        begin
            // A capacity write empties the deque.
            cap_next   = cap_clamp;
            head_next  = '0;
            tail_next  = cap_last[PTR_W-1:0];
            count_next = '0;
        end
        else if (accept)
        begin
            case (cmd.cmd)
                CMD_PUSH_BACK:
                begin
                    slot_we = 1'b1;
                    if (full)
                    begin
                        // The front element is overwritten and the window moves on.
                        slot_waddr = head_reg;
                        tail_next  = head_reg;
                        head_next  = inc_head;
                    end
                    else
                    begin
                        slot_waddr = inc_tail;
                        tail_next  = inc_tail;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_PUSH_FRONT:
                begin
                    slot_we = 1'b1;
                    if (full)
                    begin
                        // The back element is overwritten and the window moves back.
                        slot_waddr = tail_reg;
                        head_next  = tail_reg;
                        tail_next  = dec_tail;
                    end
                    else
                    begin
                        slot_waddr = dec_head;
                        head_next  = dec_head;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP_BACK:
                begin
                    if (count_reg != '0)
                    begin
                        tail_next  = dec_tail;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (count_reg != '0)
                    begin
                        head_next  = inc_head;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_READ:
                begin
                    if (read_idx < count_reg)
                    begin
                        result.read_data = RD_W'(slots_reg[read_pos[PTR_W-1:0]]);
                    end
                    else
                    begin
                        result.index_error = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    head_next  = '0;
                    tail_next  = cap_last[PTR_W-1:0];
                    count_next = '0;
                end
                default:
                begin
                    // Unused codes only report the status.
                end
            endcase
        end

        result.element_count = count_next;
        result.is_empty      = (count_next == '0);
        result.is_full       = (count_next == cap_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CNT_W'(DEPTH);
            head_reg  <= '0;
            tail_reg  <= PTR_W'(DEPTH - 1);
            count_reg <= '0;
        end
        else
        begin
            cap_reg   <= cap_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Slot storage holds payload only and is not reset.
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slots_reg[slot_waddr] <= DATA_WIDTH'(cmd.element_value);
        end
    end

    ord_rsp_buf u_rsp_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (accept && !cfg_we),
        .push_ready (buf_ready),
        .push_data  (result),
        .rsp        (rsp)
    );

endmodule
